/* hdl/wicm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wicm_pkg
// Shared widths, types and constants of the weighted increasing chain block.
// ----------------------------------------------------------------------------
package wicm_pkg;

  localparam int unsigned KEYS_DEFAULT    = 1024;
  localparam int unsigned KEY_W           = 11;
  localparam int unsigned WEIGHT_W        = 32;
  localparam int unsigned VAL_W           = 42;
  localparam int unsigned POS_W           = KEY_W + 1;
  localparam int unsigned EPOCH_W         = 4;
  localparam int unsigned KEY_COUNT_RESET = 1024;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [EPOCH_W-1:0]  epoch_t;

  localparam val_t   VAL_MAX   = '1;
  localparam epoch_t EPOCH_MAX = '1;

  typedef struct packed {
    epoch_t tag;
    val_t   val;
  } tree_entry_t;

endpackage : wicm_pkg
`default_nettype wire

/* hdl/wicm_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wicm_item_if / wicm_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface wicm_item_if;
  import wicm_pkg::*;

  logic    valid;
  logic    ready;
  key_t    key;
  weight_t weight;
  logic    restart;

  modport source (output valid, output key, output weight, output restart, input ready);
  modport sink   (input valid, input key, input weight, input restart, output ready);
endinterface : wicm_item_if

interface wicm_result_if;
  import wicm_pkg::*;

  logic valid;
  logic ready;
  val_t chain_value;
  val_t best_so_far;
  logic key_error;

  modport source (output valid, output chain_value, output best_so_far, output key_error,
                  input ready);
  modport sink   (input valid, input chain_value, input best_so_far, input key_error,
                  output ready);
endinterface : wicm_result_if
`default_nettype wire

/* hdl/wicm_tree_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wicm_tree_mem
// Prefix-maximum tree store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wicm_tree_mem #(
  parameter int unsigned KEYS   = wicm_pkg::KEYS_DEFAULT,
  parameter int unsigned ADDR_W = $clog2(KEYS)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ADDR_W-1:0]     waddr,
  input  wire wicm_pkg::tree_entry_t wdata,
  input  wire logic [ADDR_W-1:0]     raddr,
  output      wicm_pkg::tree_entry_t rdata
);
  import wicm_pkg::*;

  tree_entry_t mem [KEYS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : wicm_tree_mem
`default_nettype wire

/* hdl/wicm_cmp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wicm_cmp
// Shared magnitude comparator with maximum select.
// ----------------------------------------------------------------------------
module wicm_cmp (
  input  wire wicm_pkg::val_t a,
  input  wire wicm_pkg::val_t b,
  output      logic           gt,
  output      wicm_pkg::val_t hi
);
  import wicm_pkg::*;

  assign gt = (a > b);
  assign hi = gt ? a : b;

endmodule : wicm_cmp
`default_nettype wire

/* hdl/weighted_increasing_chain_max.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_increasing_chain_max
// Maximum-weight strictly increasing chain by key over a prefix-maximum tree.
// ----------------------------------------------------------------------------
// One item is handled at a time. The query walk reads popcount(key-1) tree
// nodes and the update walk reads the nodes on the path up to the key bound;
// a rejected key skips both walks. The query and update walks each make one
// tree read per cycle through the single read port of the tree store, sharing
// one comparator. After reset, and on every 16th restart when the 4-bit tree
// epoch wraps, a clearing pass over all KEYS entries runs before any item
// proceeds; other restarts only advance the epoch. A finished result waits in
// an output register while the next item is accepted.
module weighted_increasing_chain_max #(
  parameter int unsigned KEYS = wicm_pkg::KEYS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  wicm_item_if.sink                item,
  wicm_result_if.source            result,
  input  wire logic                cfg_we,
  input  wire wicm_pkg::key_t      cfg_data
);
  import wicm_pkg::*;

  localparam int unsigned ADDR_W      = $clog2(KEYS);
  localparam int unsigned KEY_MAXV    = (2 ** KEY_W) - 1;
  localparam int unsigned KEY_LIMIT   = (KEYS < KEY_MAXV) ? KEYS : KEY_MAXV;
  localparam int unsigned BOUND_RESET =
    (KEY_COUNT_RESET < KEY_LIMIT) ? KEY_COUNT_RESET : KEY_LIMIT;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_QUERY = 7'b0000100,
    S_SUM   = 7'b0001000,
    S_BEST  = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t              state;
  key_t                bound;
  key_t                item_key;
  weight_t             weight;
  logic                err;
  logic                busy;
  logic                rd_v;
  pos_t                qpos;
  pos_t                upos;
  logic [ADDR_W-1:0]   uaddr;
  logic [ADDR_W-1:0]   clr_addr;
  val_t                acc;
  val_t                chain;
  val_t                best;
  epoch_t              epoch;

  logic                res_valid;
  val_t                res_chain;
  val_t                res_best;
  logic                res_err;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  tree_entry_t         mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  tree_entry_t         mem_rdata;

  val_t                rd_eff;
  val_t                cmp_a;
  val_t                cmp_b;
  logic                cmp_gt;
  val_t                cmp_hi;
  pos_t                rd_pos;
  pos_t                qpos_step;
  pos_t                upos_step;
  logic                upos_in;
  logic [VAL_W:0]      sum;
  val_t                chain_sat;
  logic                key_bad;
  logic                item_acc;
  key_t                bound_cfg;

  wicm_tree_mem #(
    .KEYS   (KEYS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wicm_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (cmp_gt),
    .hi (cmp_hi)
  );

  assign rd_eff    = (mem_rdata.tag == epoch) ? mem_rdata.val : '0;
  assign qpos_step = qpos & (qpos - POS_W'(1));
  assign upos_step = upos + (upos & (~upos + POS_W'(1)));
  assign upos_in   = (upos <= {1'b0, bound});
  assign rd_pos    = (state == S_UPD) ? upos : qpos;
  assign mem_raddr = ADDR_W'(rd_pos - POS_W'(1));
  assign sum       = {1'b0, acc} + (VAL_W + 1)'(weight);
  assign chain_sat = sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];
  assign key_bad   = (item.key == '0) || (item.key > bound);
  assign item_acc  = item.valid && item.ready;
  assign bound_cfg = (cfg_data > KEY_W'(KEY_LIMIT)) ? KEY_W'(KEY_LIMIT) : cfg_data;

  always_comb begin
    case (state)
      S_QUERY: begin
        cmp_a = rd_eff;
        cmp_b = acc;
      end
      S_UPD: begin
        cmp_a = chain;
        cmp_b = rd_eff;
      end
      default: begin
        cmp_a = chain;
        cmp_b = best;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_UPD: begin
        mem_we    = rd_v && cmp_gt;
        mem_waddr = uaddr;
        mem_wdata = '{tag: epoch, val: chain};
      end
      default: begin
        mem_we    = 1'b0;
        mem_waddr = uaddr;
        mem_wdata = '{tag: epoch, val: chain};
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      bound <= KEY_W'(BOUND_RESET);
    end else if (cfg_we) begin
      bound <= bound_cfg;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      epoch     <= '0;
      best      <= '0;
      busy      <= 1'b0;
      rd_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(KEYS - 1)) begin
            busy <= 1'b0;
            if (!busy) begin
              state <= S_IDLE;
            end else if (err) begin
              state <= S_DONE;
            end else begin
              state <= S_QUERY;
            end
          end
        end
        S_IDLE: begin
          if (item_acc) begin
            item_key <= item.key;
            weight   <= item.weight;
            err      <= key_bad;
            acc      <= '0;
            rd_v     <= 1'b0;
            qpos     <= {1'b0, item.key} - POS_W'(1);
            state    <= key_bad ? S_DONE : S_QUERY;
            if (item.restart) begin
              best <= '0;
              if (epoch == EPOCH_MAX) begin
                epoch    <= '0;
                clr_addr <= '0;
                busy     <= 1'b1;
                state    <= S_CLEAR;
              end else begin
                epoch <= epoch + EPOCH_W'(1);
              end
            end
          end
        end
        S_QUERY: begin
          if (rd_v) begin
            acc <= cmp_hi;
          end
          if (qpos != '0) begin
            rd_v <= 1'b1;
            qpos <= qpos_step;
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          chain <= chain_sat;
          upos  <= {1'b0, item_key};
          state <= S_BEST;
        end
        S_BEST: begin
          best  <= cmp_hi;
          rd_v  <= 1'b0;
          state <= S_UPD;
        end
        S_UPD: begin
          if (upos_in) begin
            rd_v  <= 1'b1;
            uaddr <= mem_raddr;
            upos  <= upos_step;
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_chain <= err ? '0 : chain;
            res_best  <= best;
            res_err   <= err;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.chain_value = res_chain;
  assign result.best_so_far = res_best;
  assign result.key_error   = res_err;

`ifndef ASSERT_OFF
  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.key_error |-> result.chain_value == '0)
    else $error("rejected key delivered a nonzero chain value");

  a_best_covers : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.key_error |-> result.best_so_far >= result.chain_value)
    else $error("running best below the delivered chain value");

  a_load_done : assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside the completion step");

  a_clear_epoch : assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> epoch == '0)
    else $error("epoch moved during the clearing pass");
`endif

endmodule : weighted_increasing_chain_max
`default_nettype wire
